### hdl/vgf_pkg.sv
// shared types and constants for the vortex generator force block
package vgf_pkg;

	localparam int VEL_W   = 24;
	localparam int RHO_W   = 16;
	localparam int AREA_W  = 24;
	localparam int FORCE_W = 48;
	localparam int GAIN_W  = 24;
	localparam int DIR_W   = 48;
	localparam int CFG_IDX_W = 8;
	localparam int LANES   = 3;
	localparam int RAD_W   = 64;
	localparam int ROOT_W  = 32;
	localparam int MAG_W   = 40;
	localparam int K_W     = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TANGENT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPAN    = 8'd3;

	typedef struct packed {
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic signed [VEL_W-1:0] vel_z;
		logic [RHO_W-1:0]        density;
		logic [AREA_W-1:0]       area;
	} point_t;

	typedef struct packed {
		logic signed [FORCE_W-1:0] force_x;
		logic signed [FORCE_W-1:0] force_y;
		logic signed [FORCE_W-1:0] force_z;
		logic                      zero_velocity;
		logic                      saturated;
	} force_t;

	// data riding alongside the square root
	typedef struct packed {
		logic [K_W-1:0]   k;
		logic [MAG_W-1:0] adt;
		logic [MAG_W-1:0] adn;
		logic [MAG_W-1:0] ac0;
		logic [MAG_W-1:0] ac1;
		logic [MAG_W-1:0] ac2;
		logic [LANES-1:0] neg;
		logic             zero;
	} root_side_t;

	// data riding alongside the divider
	typedef struct packed {
		logic [K_W-1:0]   k;
		logic [MAG_W-1:0] adt;
		logic [MAG_W-1:0] adn;
		logic [LANES-1:0] neg;
		logic             zero;
	} div_side_t;

	// data riding alongside the product chain
	typedef struct packed {
		logic [MAG_W-1:0]  adn;
		logic [ROOT_W-1:0] e0;
		logic [ROOT_W-1:0] e1;
		logic [ROOT_W-1:0] e2;
		logic [LANES-1:0]  neg;
		logic              zero;
	} tail_t;

endpackage

### hdl/vgf_sqrt.sv
// pipelined integer square root, one result bit per stage
module vgf_sqrt #(
	parameter int WS = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_v,
	input  logic [vgf_pkg::RAD_W-1:0]   rad,
	input  logic [WS-1:0]               side_in,
	output logic                        out_v,
	output logic [vgf_pkg::ROOT_W-1:0]  root,
	output logic [WS-1:0]               side_out
);

	localparam int N = vgf_pkg::ROOT_W;
	localparam int RW = vgf_pkg::RAD_W;

	logic          v_s    [N];
	logic [RW-1:0] rem_s  [N];
	logic [N-1:0]  root_s [N];
	logic [WS-1:0] side_s [N];

	for (genvar g = 0; g < N; g++) begin : g_step
		localparam int B = N - 1 - g;
		logic          pv;
		logic [RW-1:0] prem;
		logic [N-1:0]  proot;
		logic [WS-1:0] pside;
		logic [RW:0]   term;
		logic          take;

		if (g == 0) begin : g_first
			assign pv    = in_v;
			assign prem  = rad;
			assign proot = '0;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = v_s[g-1];
			assign prem  = rem_s[g-1];
			assign proot = root_s[g-1];
			assign pside = side_s[g-1];
		end

		// trial subtract of (2r + 2^b) * 2^b
		always_comb begin
			term = ((RW+1)'(proot) << (B + 1)) + ((RW+1)'(1) << (2 * B));
			take = (RW+1)'(prem) >= term;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= take ? (prem - term[RW-1:0]) : prem;
				root_s[g] <= take ? (proot | (N'(1) << B)) : proot;
				side_s[g] <= pside;
			end
		end
	end

	assign out_v    = v_s[N-1];
	assign root     = root_s[N-1];
	assign side_out = side_s[N-1];

endmodule

### hdl/vgf_div.sv
// pipelined restoring divider, three lanes sharing one divisor
module vgf_div #(
	parameter int WS = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_v,
	input  logic [vgf_pkg::RAD_W-1:0]   num [vgf_pkg::LANES],
	input  logic [vgf_pkg::ROOT_W-1:0]  dvs,
	input  logic [WS-1:0]               side_in,
	output logic                        out_v,
	output logic [vgf_pkg::ROOT_W-1:0]  quo [vgf_pkg::LANES],
	output logic [WS-1:0]               side_out
);

	localparam int N  = vgf_pkg::ROOT_W;
	localparam int RW = vgf_pkg::RAD_W;
	localparam int L  = vgf_pkg::LANES;

	logic          v_s    [N];
	logic [RW-1:0] rem_s  [N][L];
	logic [N-1:0]  quo_s  [N][L];
	logic [N-1:0]  dvs_s  [N];
	logic [WS-1:0] side_s [N];

	for (genvar g = 0; g < N; g++) begin : g_step
		localparam int B = N - 1 - g;
		logic          pv;
		logic [RW-1:0] prem [L];
		logic [N-1:0]  pquo [L];
		logic [N-1:0]  pdvs;
		logic [WS-1:0] pside;
		logic [RW-1:0] dsh;
		logic [L-1:0]  take;

		if (g == 0) begin : g_first
			assign pv    = in_v;
			assign prem  = num;
			assign pquo  = '{default: '0};
			assign pdvs  = dvs;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = v_s[g-1];
			assign prem  = rem_s[g-1];
			assign pquo  = quo_s[g-1];
			assign pdvs  = dvs_s[g-1];
			assign pside = side_s[g-1];
		end

		always_comb begin
			dsh = RW'(pdvs) << B;
			for (int l = 0; l < L; l++) begin
				take[l] = prem[l] >= dsh;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < L; l++) begin
					rem_s[g][l] <= take[l] ? (prem[l] - dsh) : prem[l];
					quo_s[g][l] <= take[l] ? (pquo[l] | (N'(1) << B)) : pquo[l];
				end
				dvs_s[g]  <= pdvs;
				side_s[g] <= pside;
			end
		end
	end

	assign out_v    = v_s[N-1];
	assign quo      = quo_s[N-1];
	assign side_out = side_s[N-1];

endmodule

### hdl/vortex_generator_force.sv
// vortex generator point force: -G*rho*area*(v.t)(v.n)*(v x b)/|v| in saturating fixed point
//
// One actuator point (velocity Q12.12, density Q4.12, area Q8.16) goes in per request and one
// force (signed Q32.16 per axis, saturated) comes out per request, in order. The pipeline takes
// a new point every cycle while the skid register is empty; a result passes three front
// stages for the dot, cross and square sums, 32 stages of the bitwise square root of |v|^2,
// 32 stages of the three-lane divider forming (v x b)/|v|, six stages of split multiplies and
// the output register. When the output side stalls, one further result is caught in a skid
// register and the input stall then rises; nothing is dropped. Configuration (gain, tangent,
// normal and span vectors) is written through the cfg port, always ready, and must only change
// while no point is in flight. Zero velocity yields a zero force with zero_velocity set.
module vortex_generator_force (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pt_valid,
	output logic                               pt_stall,
	input  vgf_pkg::point_t                    pt,
	output logic                               frc_valid,
	input  logic                               frc_stall,
	output vgf_pkg::force_t                    frc,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [vgf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vgf_pkg::DIR_W-1:0]          cfg_data
);

	localparam int L  = vgf_pkg::LANES;
	localparam int MW = vgf_pkg::MAG_W;
	localparam int RW = vgf_pkg::ROOT_W;
	localparam int KW = vgf_pkg::K_W;
	localparam int FW = vgf_pkg::FORCE_W;
	localparam int KT_W  = KW + MW;           // k * |v.t|
	localparam int KTN_W = KT_W + MW;         // times |v.n|
	localparam int P_W   = KTN_W + RW;        // times |e|
	localparam int KT_CH  = (KT_W + 31) / 32;
	localparam int KTN_CH = (KTN_W + 31) / 32;
	localparam int SHIFT  = 110;              // Q.126 down to Q.16
	localparam int OVF_B  = SHIFT + FW;

	// configuration registers
	logic [vgf_pkg::GAIN_W-1:0] gain_q;
	logic [vgf_pkg::DIR_W-1:0]  tan_q, nrm_q, span_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
			tan_q  <= '0;
			nrm_q  <= '0;
			span_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				vgf_pkg::CFG_GAIN:    gain_q <= cfg_data[vgf_pkg::GAIN_W-1:0];
				vgf_pkg::CFG_TANGENT: tan_q  <= cfg_data;
				vgf_pkg::CFG_NORMAL:  nrm_q  <= cfg_data;
				vgf_pkg::CFG_SPAN:    span_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline moves whenever the skid register is empty
	logic adv;
	logic skid_v_q, out_v_q;
	assign adv      = !skid_v_q;
	assign pt_stall = skid_v_q;

	logic acc;
	assign acc = pt_valid & !pt_stall;

	// unpacked direction components, x low, z high
	logic signed [15:0] tv [L], nv [L], bv [L];
	always_comb begin
		for (int i = 0; i < L; i++) begin
			tv[i] = tan_q[16*i +: 16];
			nv[i] = nrm_q[16*i +: 16];
			bv[i] = span_q[16*i +: 16];
		end
	end

	logic signed [vgf_pkg::VEL_W-1:0] vv [L];
	assign vv[0] = pt.vel_x;
	assign vv[1] = pt.vel_y;
	assign vv[2] = pt.vel_z;

	// stage 1: all the narrow products
	logic                v_s1;
	logic signed [39:0]  pt_s1 [L];
	logic signed [39:0]  pn_s1 [L];
	logic signed [47:0]  sq_s1 [L];
	logic signed [39:0]  cp_s1 [6];
	logic [39:0]         gr_s1;
	logic [vgf_pkg::AREA_W-1:0] area_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < L; i++) begin
				pt_s1[i] <= 40'(vv[i]) * 40'(tv[i]);
				pn_s1[i] <= 40'(vv[i]) * 40'(nv[i]);
				sq_s1[i] <= 48'(vv[i]) * 48'(vv[i]);
			end
			// cross product terms
			cp_s1[0] <= 40'(vv[1]) * 40'(bv[2]);
			cp_s1[1] <= 40'(vv[2]) * 40'(bv[1]);
			cp_s1[2] <= 40'(vv[2]) * 40'(bv[0]);
			cp_s1[3] <= 40'(vv[0]) * 40'(bv[2]);
			cp_s1[4] <= 40'(vv[0]) * 40'(bv[1]);
			cp_s1[5] <= 40'(vv[1]) * 40'(bv[0]);
			gr_s1    <= 40'(gain_q) * 40'(pt.density);
			area_s1  <= pt.area;
		end
	end

	// stage 2: sums, gain times area
	logic                v_s2;
	logic signed [41:0]  dt_s2, dn_s2;
	logic [47:0]         ss_s2;
	logic signed [40:0]  c_s2 [L];
	logic [KW-1:0]       k_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dt_s2   <= 42'(pt_s1[0]) + 42'(pt_s1[1]) + 42'(pt_s1[2]);
			dn_s2   <= 42'(pn_s1[0]) + 42'(pn_s1[1]) + 42'(pn_s1[2]);
			ss_s2   <= sq_s1[0][47:0] + sq_s1[1][47:0] + sq_s1[2][47:0];
			c_s2[0] <= 41'(cp_s1[0]) - 41'(cp_s1[1]);
			c_s2[1] <= 41'(cp_s1[2]) - 41'(cp_s1[3]);
			c_s2[2] <= 41'(cp_s1[4]) - 41'(cp_s1[5]);
			k_s2    <= KW'(gr_s1) * KW'(area_s1);
		end
	end

	// stage 3: magnitudes, signs, radicand
	logic [41:0] adt_w, adn_w;
	logic [40:0] ac_w [L];
	vgf_pkg::root_side_t rs_w;

	always_comb begin
		adt_w = dt_s2[41] ? 42'(-dt_s2) : 42'(dt_s2);
		adn_w = dn_s2[41] ? 42'(-dn_s2) : 42'(dn_s2);
		for (int i = 0; i < L; i++) begin
			ac_w[i] = c_s2[i][40] ? 41'(-c_s2[i]) : 41'(c_s2[i]);
		end
		rs_w.k    = k_s2;
		rs_w.adt  = adt_w[MW-1:0];
		rs_w.adn  = adn_w[MW-1:0];
		rs_w.ac0  = ac_w[0][MW-1:0];
		rs_w.ac1  = ac_w[1][MW-1:0];
		rs_w.ac2  = ac_w[2][MW-1:0];
		// force is negative when the three signs agree in an even count
		for (int i = 0; i < L; i++) begin
			rs_w.neg[i] = ~(dt_s2[41] ^ dn_s2[41] ^ c_s2[i][40]);
		end
		rs_w.zero = (ss_s2 == '0);
	end

	logic                      v_s3;
	logic [vgf_pkg::RAD_W-1:0] rad_s3;
	vgf_pkg::root_side_t       rs_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3 <= {ss_s2, 16'd0};
			rs_s3  <= rs_w;
		end
	end

	// |v| in Q.20
	logic                sq_v;
	logic [RW-1:0]       sq_root;
	vgf_pkg::root_side_t sq_side;

	vgf_sqrt #(
		.WS($bits(vgf_pkg::root_side_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_v     (v_s3),
		.rad      (rad_s3),
		.side_in  (rs_s3),
		.out_v    (sq_v),
		.root     (sq_root),
		.side_out (sq_side)
	);

	// direction term (v x b)/|v| per axis in Q.30
	logic [vgf_pkg::RAD_W-1:0] num_w [L];
	vgf_pkg::div_side_t        ds_w;

	always_comb begin
		num_w[0]  = {sq_side.ac0, 24'd0};
		num_w[1]  = {sq_side.ac1, 24'd0};
		num_w[2]  = {sq_side.ac2, 24'd0};
		ds_w.k    = sq_side.k;
		ds_w.adt  = sq_side.adt;
		ds_w.adn  = sq_side.adn;
		ds_w.neg  = sq_side.neg;
		ds_w.zero = sq_side.zero;
	end

	logic               dv_v;
	logic [RW-1:0]      dv_quo [L];
	vgf_pkg::div_side_t dv_side;

	vgf_div #(
		.WS($bits(vgf_pkg::div_side_t))
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_v     (sq_v),
		.num      (num_w),
		.dvs      (sq_root),
		.side_in  (ds_w),
		.out_v    (dv_v),
		.quo      (dv_quo),
		.side_out (dv_side)
	);

	vgf_pkg::tail_t tl_w;
	always_comb begin
		tl_w.adn  = dv_side.adn;
		tl_w.e0   = dv_quo[0];
		tl_w.e1   = dv_quo[1];
		tl_w.e2   = dv_quo[2];
		tl_w.neg  = dv_side.neg;
		tl_w.zero = dv_side.zero;
	end

	// product chain, each multiply split into 32-bit slices then summed
	logic               v_m1, v_m2, v_m3, v_m4, v_m5, v_m6;
	vgf_pkg::tail_t     tl_m1, tl_m2, tl_m3, tl_m4, tl_m5, tl_m6;
	logic [31+MW:0]     pa_m1 [2];
	logic [KT_W-1:0]    kt_m2;
	logic [31+MW:0]     pb_m3 [KT_CH];
	logic [KTN_W-1:0]   ktn_m4;
	logic [63:0]        pc_m5 [L][KTN_CH];
	logic [P_W-1:0]     p_m6 [L];

	logic [32*KT_CH-1:0]  kt_pad;
	logic [32*KTN_CH-1:0] ktn_pad;
	logic [RW-1:0]        e_m4 [L];
	logic [P_W-1:0]       psum [L];
	logic [KTN_W-1:0]     bsum;

	assign kt_pad  = (32*KT_CH)'(kt_m2);
	assign ktn_pad = (32*KTN_CH)'(ktn_m4);
	assign e_m4[0] = tl_m4.e0;
	assign e_m4[1] = tl_m4.e1;
	assign e_m4[2] = tl_m4.e2;

	always_comb begin
		bsum = '0;
		for (int j = 0; j < KT_CH; j++) begin
			bsum = bsum + (KTN_W'(pb_m3[j]) << (32 * j));
		end
		for (int i = 0; i < L; i++) begin
			psum[i] = '0;
			for (int j = 0; j < KTN_CH; j++) begin
				psum[i] = psum[i] + (P_W'(pc_m5[i][j]) << (32 * j));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_m3 <= 1'b0;
			v_m4 <= 1'b0;
			v_m5 <= 1'b0;
			v_m6 <= 1'b0;
		end else if (adv) begin
			v_m1 <= dv_v;
			v_m2 <= v_m1;
			v_m3 <= v_m2;
			v_m4 <= v_m3;
			v_m5 <= v_m4;
			v_m6 <= v_m5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// k times |v.t|
			pa_m1[0] <= (32+MW)'(dv_side.k[31:0]) * (32+MW)'(dv_side.adt);
			pa_m1[1] <= (32+MW)'(dv_side.k[63:32]) * (32+MW)'(dv_side.adt);
			tl_m1    <= tl_w;
			kt_m2    <= KT_W'(pa_m1[0]) + (KT_W'(pa_m1[1]) << 32);
			tl_m2    <= tl_m1;
			// times |v.n|
			for (int j = 0; j < KT_CH; j++) begin
				pb_m3[j] <= (32+MW)'(kt_pad[32*j +: 32]) * (32+MW)'(tl_m2.adn);
			end
			tl_m3  <= tl_m2;
			ktn_m4 <= bsum;
			tl_m4  <= tl_m3;
			// times each direction term
			for (int i = 0; i < L; i++) begin
				for (int j = 0; j < KTN_CH; j++) begin
					pc_m5[i][j] <= 64'(ktn_pad[32*j +: 32]) * 64'(e_m4[i]);
				end
			end
			tl_m5 <= tl_m4;
			p_m6  <= psum;
			tl_m6 <= tl_m5;
		end
	end

	// truncate, sign, saturate
	logic [FW-1:0] fval [L];
	logic [L-1:0]  fsat;
	vgf_pkg::force_t res_w;

	always_comb begin
		logic [FW:0] mag;
		logic        ng;
		for (int i = 0; i < L; i++) begin
			if (|p_m6[i][P_W-1:OVF_B]) begin
				mag = (FW+1)'(1) << FW;
			end else begin
				mag = (FW+1)'(p_m6[i][OVF_B-1:SHIFT]);
			end
			ng = tl_m6.neg[i] & (mag != '0);
			fsat[i] = 1'b0;
			if (ng) begin
				if (mag > ((FW+1)'(1) << (FW - 1))) begin
					mag     = (FW+1)'(1) << (FW - 1);
					fsat[i] = 1'b1;
				end
				fval[i] = FW'(-mag);
			end else begin
				if (mag > (((FW+1)'(1) << (FW - 1)) - (FW+1)'(1))) begin
					mag     = ((FW+1)'(1) << (FW - 1)) - (FW+1)'(1);
					fsat[i] = 1'b1;
				end
				fval[i] = mag[FW-1:0];
			end
		end
		if (tl_m6.zero) begin
			res_w.force_x       = '0;
			res_w.force_y       = '0;
			res_w.force_z       = '0;
			res_w.zero_velocity = 1'b1;
			res_w.saturated     = 1'b0;
		end else begin
			res_w.force_x       = fval[0];
			res_w.force_y       = fval[1];
			res_w.force_z       = fval[2];
			res_w.zero_velocity = 1'b0;
			res_w.saturated     = |fsat;
		end
	end

	// output register with a skid behind it
	vgf_pkg::force_t out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!skid_v_q) begin
			if (!out_v_q || !frc_stall) begin
				out_v_q <= v_m6;
			end else begin
				skid_v_q <= v_m6;
			end
		end else if (!frc_stall) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			if (!out_v_q || !frc_stall) begin
				out_q <= res_w;
			end else begin
				skid_q <= res_w;
			end
		end else if (!frc_stall) begin
			out_q <= skid_q;
		end
	end

	assign frc_valid = out_v_q;
	assign frc       = out_q;

endmodule

### tb/vortex_generator_force_tb.sv
// testbench for the vortex generator point force block: random points checked against a predictor
module vortex_generator_force_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// expected forces, worked out from the configured gain and vectors
	class force_board;
		logic [vgf_pkg::GAIN_W-1:0] gain;
		logic [vgf_pkg::DIR_W-1:0]  tangent;
		logic [vgf_pkg::DIR_W-1:0]  normal;
		logic [vgf_pkg::DIR_W-1:0]  span;
		vgf_pkg::force_t            pending[$];
		int                         errors;

		function new();
			gain = '0;
			tangent = '0;
			normal = '0;
			span = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [vgf_pkg::CFG_IDX_W-1:0] idx,
			logic [vgf_pkg::DIR_W-1:0] data);
			case (idx)
				vgf_pkg::CFG_GAIN: begin
					gain = data[vgf_pkg::GAIN_W-1:0];
				end
				vgf_pkg::CFG_TANGENT: begin
					tangent = data;
				end
				vgf_pkg::CFG_NORMAL: begin
					normal = data;
				end
				vgf_pkg::CFG_SPAN: begin
					span = data;
				end
				default: begin
				end
			endcase
		endfunction

		// floor of the square root, bit by bit
		function automatic logic [63:0] root_floor(logic [63:0] x);
			logic [63:0] rem, res, b;
			rem = x;
			res = 0;
			b = 64'd1 << 62;
			while (b > rem) b = b >> 2;
			while (b != 0) begin
				if (rem >= res + b) begin
					rem = rem - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function automatic longint part(logic [vgf_pkg::DIR_W-1:0] r, int i);
			return longint'($signed(r[16*i +: 16]));
		endfunction

		function automatic logic [63:0] abs_of(longint x);
			return x < 0 ? 64'(-x) : 64'(x);
		endfunction

		// note one accepted point and queue the force it should give
		function void note(vgf_pkg::point_t p);
			longint      v[3], c[3];
			longint      dt, dn;
			logic [63:0] sumsq, rad, k, e, m;
			logic [255:0] prod;
			logic [vgf_pkg::FORCE_W-1:0] out[3];
			logic        neg, sat;
			vgf_pkg::force_t r;
			v[0] = longint'(p.vel_x);
			v[1] = longint'(p.vel_y);
			v[2] = longint'(p.vel_z);
			dt = 0;
			dn = 0;
			sumsq = 0;
			sat = 0;
			for (int i = 0; i < 3; i++) begin
				dt += v[i] * part(tangent, i);
				dn += v[i] * part(normal, i);
				sumsq += 64'(v[i] * v[i]);
			end
			r = '0;
			if (sumsq == 0) begin
				r.zero_velocity = 1'b1;
				pending.push_back(r);
				return;
			end
			c[0] = v[1] * part(span, 2) - v[2] * part(span, 1);
			c[1] = v[2] * part(span, 0) - v[0] * part(span, 2);
			c[2] = v[0] * part(span, 1) - v[1] * part(span, 0);
			rad = root_floor(sumsq << 16);
			k = 64'(gain) * 64'(p.density) * 64'(p.area);
			for (int i = 0; i < 3; i++) begin
				e = (abs_of(c[i]) << 24) / rad;
				prod = 256'(k) * 256'(abs_of(dt)) * 256'(abs_of(dn)) * 256'(e);
				// anything at or above 2^48 in Q.16 is capped, it clips either way
				if (prod[255:158] != 0) m = 64'd1 << 48;
				else m = 64'(prod[157:110]);
				neg = !((dt < 0) ^ (dn < 0) ^ (c[i] < 0));
				if (m == 0) neg = 0;
				if (neg) begin
					if (m > 64'h8000_0000_0000) begin
						m = 64'h8000_0000_0000;
						sat = 1;
					end
					out[i] = 48'(-m);
				end else begin
					if (m > 64'h7FFF_FFFF_FFFF) begin
						m = 64'h7FFF_FFFF_FFFF;
						sat = 1;
					end
					out[i] = 48'(m);
				end
			end
			r.force_x = out[0];
			r.force_y = out[1];
			r.force_z = out[2];
			r.saturated = sat;
			pending.push_back(r);
		endfunction

		function void check(vgf_pkg::force_t got);
			vgf_pkg::force_t want;
			if (pending.size() == 0) begin
				$display("%t: force with none expected: %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.force_x !== want.force_x) begin
				$display("%t: force_x expected %h actual %h", $time, want.force_x, got.force_x);
				errors++;
			end
			if (got.force_y !== want.force_y) begin
				$display("%t: force_y expected %h actual %h", $time, want.force_y, got.force_y);
				errors++;
			end
			if (got.force_z !== want.force_z) begin
				$display("%t: force_z expected %h actual %h", $time, want.force_z, got.force_z);
				errors++;
			end
			if (got.zero_velocity !== want.zero_velocity) begin
				$display("%t: zero_velocity expected %b actual %b", $time,
					want.zero_velocity, got.zero_velocity);
				errors++;
			end
			if (got.saturated !== want.saturated) begin
				$display("%t: saturated expected %b actual %b", $time,
					want.saturated, got.saturated);
				errors++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          pt_valid;
	logic                          pt_stall;
	vgf_pkg::point_t               pt;
	logic                          frc_valid;
	logic                          frc_stall;
	vgf_pkg::force_t               frc;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [vgf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [vgf_pkg::DIR_W-1:0]     cfg_data;

	force_board board;
	bit         calm;   // no idling on either side while set

	vortex_generator_force DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pt_valid(pt_valid),
		.pt_stall(pt_stall),
		.pt(pt),
		.frc_valid(frc_valid),
		.frc_stall(frc_stall),
		.frc(frc),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic bit idle_draw();
		return calm ? 1'b0 : ($urandom_range(99) < 29);
	endfunction

	// output side stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frc_stall <= 1'b0;
		end else begin
			frc_stall <= idle_draw();
		end
	end

	// monitors: every accepted request, config write and result, sampled at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
			if (pt_valid && !pt_stall) board.note(pt);
			if (frc_valid && !frc_stall) board.check(frc);
		end
	end

	// one point request, with a random gap in front, held until taken
	task automatic send_point(vgf_pkg::point_t p);
		while (idle_draw()) begin
			pt_valid <= 1'b0;
			@(posedge clk);
		end
		pt <= p;
		pt_valid <= 1'b1;
		@(posedge clk);
		while (pt_stall) @(posedge clk);
	endtask

	task automatic write_reg(logic [vgf_pkg::CFG_IDX_W-1:0] idx,
		logic [vgf_pkg::DIR_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// drain the pipeline before touching the registers
	task automatic drain();
		pt_valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic vgf_pkg::point_t make_point(logic signed [vgf_pkg::VEL_W-1:0] x,
		logic signed [vgf_pkg::VEL_W-1:0] y, logic signed [vgf_pkg::VEL_W-1:0] z,
		logic [vgf_pkg::RHO_W-1:0] rho, logic [vgf_pkg::AREA_W-1:0] ar);
		vgf_pkg::point_t p;
		p.vel_x = x;
		p.vel_y = y;
		p.vel_z = z;
		p.density = rho;
		p.area = ar;
		return p;
	endfunction

	function automatic logic [vgf_pkg::VEL_W-1:0] rand_vel(int mode);
		case (mode)
			0: return '0;
			1: return 24'($signed($urandom_range(8191)) - 4096);
			2: return $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic vgf_pkg::point_t rand_point();
		int  kind;
		int  m[3];
		kind = $urandom_range(9);
		for (int i = 0; i < 3; i++) begin
			case (kind)
				0: m[i] = 0;                        // zero velocity
				1, 2: m[i] = 1;                     // small speeds
				3: m[i] = $urandom_range(1) ? 0 : 3; // some components zero
				4: m[i] = $urandom_range(3);        // a mix, extremes too
				default: m[i] = 3;
			endcase
		end
		return make_point(rand_vel(m[0]), rand_vel(m[1]), rand_vel(m[2]),
			$urandom_range(3) == 0 ? 16'($urandom_range(15)) : 16'($urandom),
			$urandom_range(3) == 0 ? 24'($urandom_range(255)) : 24'($urandom));
	endfunction

	// a configured vector: axis units, arbitrary patterns or the extremes
	function automatic logic [vgf_pkg::DIR_W-1:0] rand_dir();
		logic [vgf_pkg::DIR_W-1:0] d;
		case ($urandom_range(4))
			0: begin
				d = '0;
				d[16*$urandom_range(2) +: 16] = $urandom_range(1) ? 16'h4000 : 16'hC000;
			end
			1: d = {3{16'h7FFF}};
			2: d = {3{16'h8000}};
			default: d = {16'($urandom), 16'($urandom), 16'($urandom)};
		endcase
		return d;
	endfunction

	initial begin
		board = new();
		calm = 1'b0;
		arst_n <= 1'b0;
		pt_valid <= 1'b0;
		pt <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: every force is zero
		for (int i = 0; i < 20; i++) send_point(rand_point());
		drain();

		// unit gain with x, y, z axes
		write_reg(vgf_pkg::CFG_GAIN, 48'h01_0000);
		write_reg(vgf_pkg::CFG_TANGENT, 48'h0000_0000_4000);
		write_reg(vgf_pkg::CFG_NORMAL, 48'h0000_4000_0000);
		write_reg(vgf_pkg::CFG_SPAN, 48'h4000_0000_0000);
		write_reg(8'd7, 48'hFFFF_FFFF_FFFF);  // out-of-range index, ignored
		// directed points: zero velocity, field extremes, signs and tiny speeds
		send_point(make_point(0, 0, 0, 16'hFFFF, 24'hFFFFFF));
		send_point(make_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 24'hFFFFFF));
		send_point(make_point(24'h800000, 24'h800000, 24'h800000, 16'hFFFF, 24'hFFFFFF));
		send_point(make_point(24'h800000, 24'h7FFFFF, 0, 16'hFFFF, 24'hFFFFFF));
		send_point(make_point(24'h7FFFFF, 24'h800000, 24'h000001, 16'h1000, 24'h010000));
		send_point(make_point(24'h001000, 24'h001000, 0, 16'h1000, 24'h010000));
		send_point(make_point(24'hFFF000, 24'h001000, 24'h001000, 16'h1000, 24'h010000));
		send_point(make_point(1, 1, 1, 16'hFFFF, 24'hFFFFFF));
		send_point(make_point(24'hFFFFFF, 1, 0, 16'hFFFF, 24'hFFFFFF));
		send_point(make_point(24'h001000, 24'h002000, 24'h003000, 0, 24'hFFFFFF));
		send_point(make_point(24'h001000, 24'h002000, 24'h003000, 16'hFFFF, 0));
		send_point(make_point(0, 0, 24'h7FFFFF, 16'hFFFF, 24'hFFFFFF));
		send_point(make_point(0, 24'h000001, 0, 16'h0001, 24'h000001));
		drain();

		// largest gain and vectors, to drive the forces into saturation
		write_reg(vgf_pkg::CFG_GAIN, 48'hFFFF_FFFF_FFFF);
		write_reg(vgf_pkg::CFG_TANGENT, {3{16'h7FFF}});
		write_reg(vgf_pkg::CFG_NORMAL, {3{16'h8000}});
		write_reg(vgf_pkg::CFG_SPAN, {16'h7FFF, 16'h8000, 16'h7FFF});
		for (int i = 0; i < 150; i++) send_point(rand_point());
		drain();

		// random settings, one of them without any idling
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(vgf_pkg::CFG_GAIN, ph == 0 ? 48'h0 : 48'($urandom));
			write_reg(vgf_pkg::CFG_TANGENT, rand_dir());
			write_reg(vgf_pkg::CFG_NORMAL, rand_dir());
			write_reg(vgf_pkg::CFG_SPAN, rand_dir());
			calm = (ph == 4);
			for (int i = 0; i < 215; i++) send_point(rand_point());
			calm = 1'b0;
			drain();
		end

		repeat (100) @(posedge clk);
		if (board.errors == 0) begin
			$display("vortex_generator_force test passed");
		end else begin
			$display("vortex_generator_force test failed");
		end
		$finish;
	end

	// hard limit on the run
	initial begin
		#5ms;
		$display("vortex_generator_force test failed");
		$finish;
	end

endmodule
